[rtl/motion_command_frame_encoder_core_macros.svh]
// ---------------------------------------------------------------------------
// motion command frame encoder: assertion macros
// concurrent checks, sampled on clk and held off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef MOTION_COMMAND_FRAME_ENCODER_CORE_MACROS_SVH
`define MOTION_COMMAND_FRAME_ENCODER_CORE_MACROS_SVH

// property must hold at every edge out of reset
`define MCFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define MCFE_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[rtl/mcfe_pkg.sv]
// ---------------------------------------------------------------------------
// mcfe_pkg
// shared types and constants of the motion command frame encoder
// ---------------------------------------------------------------------------
`default_nettype none

package mcfe_pkg;

  // command codes
  localparam logic [1:0] CMD_RECT  = 2'd0;
  localparam logic [1:0] CMD_POLAR = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_VEL_LIMIT  = 3'd0;
  localparam logic [2:0] CFG_TURN_LIMIT = 3'd1;
  localparam logic [2:0] CFG_RECT_MODE  = 3'd2;
  localparam logic [2:0] CFG_POLAR_MODE = 3'd3;
  localparam logic [2:0] CFG_STOP_MODE  = 3'd4;

  // configuration reset values
  localparam logic [12:0] VEL_LIMIT_RST  = 13'd4000;
  localparam logic [12:0] TURN_LIMIT_RST = 13'd360;
  localparam logic [7:0]  RECT_MODE_RST  = 8'd0;
  localparam logic [7:0]  POLAR_MODE_RST = 8'd1;
  localparam logic [7:0]  STOP_MODE_RST  = 8'd2;

  // status codes, by check slot (in polar mode the turn rate takes slot two)
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_FIRST_OVER   = 3'd1;
  localparam logic [2:0] ST_FIRST_UNDER  = 3'd2;
  localparam logic [2:0] ST_SECOND_OVER  = 3'd3;
  localparam logic [2:0] ST_SECOND_UNDER = 3'd4;
  localparam logic [2:0] ST_THIRD_OVER   = 3'd5;
  localparam logic [2:0] ST_THIRD_UNDER  = 3'd6;

  // frame encoding
  localparam int          FRAME_BYTES = 8;
  localparam logic [2:0]  FRAME_LAST  = 3'(FRAME_BYTES - 1);
  localparam logic [5:0]  HI_MASK     = 6'h3F;
  localparam logic [6:0]  LO_MASK     = 7'h7F;
  localparam logic [7:0]  SIGN_FLAG   = 8'h40;

  // direction wrap: x / 360 estimated as (x * RECIP_360) >> RECIP_SHIFT,
  // low by at most one for x up to 32768
  localparam logic [8:0]  DEG_FULL    = 9'd360;
  localparam logic [15:0] RECIP_360   = 16'd46603;
  localparam int          RECIP_SHIFT = 24;

  typedef logic [7:0][7:0] frame_bytes_t;

  // checked command, between the check and pack stages
  typedef struct packed {
    logic        err;
    logic [2:0]  status;
    logic        a_neg;
    logic [12:0] a_mag;
    logic        b_neg;
    logic [12:0] b_mag;
    logic        polar;
    logic        d_pos;
    logic [15:0] dx;
    logic [6:0]  dq;
    logic        c_neg;
    logic [12:0] c_mag;
    logic [7:0]  mode;
  } chk_t;

  // packed frame or error, into the serialiser
  typedef struct packed {
    logic         err;
    logic [2:0]   status;
    frame_bytes_t bytes;
  } frm_t;

endpackage

`default_nettype wire

[rtl/mcfe_check.sv]
// ---------------------------------------------------------------------------
// mcfe_check
// range checks, magnitudes and the quotient estimate for the direction wrap
// ---------------------------------------------------------------------------
`default_nettype none

module mcfe_check import mcfe_pkg::*; (
  input  wire logic [1:0]         command,
  input  wire logic signed [15:0] first_value,
  input  wire logic signed [15:0] second_value,
  input  wire logic signed [15:0] turn_rate,
  input  wire logic [12:0]        vel_limit,
  input  wire logic [12:0]        turn_limit,
  input  wire logic [7:0]         rect_mode,
  input  wire logic [7:0]         polar_mode,
  input  wire logic [7:0]         stop_mode,
  output chk_t                    chk
);

  logic signed [16:0] a_x, b_x, c_x;
  logic signed [16:0] vl_p, vl_n, tl_p, tl_n;
  logic               a_ov, a_un, b_ov, b_un, c_ov, c_un;
  logic [16:0]        a_abs, b_abs, c_abs, d_neg;
  logic               d_pos;
  logic [15:0]        dx;
  logic [31:0]        prod;

  // widened operands and limits
  assign a_x  = {first_value[15], first_value};
  assign b_x  = {second_value[15], second_value};
  assign c_x  = {turn_rate[15], turn_rate};
  assign vl_p = $signed({4'b0000, vel_limit});
  assign tl_p = $signed({4'b0000, turn_limit});
  assign vl_n = -vl_p;
  assign tl_n = -tl_p;

  // limit compares
  assign a_ov = a_x > vl_p;
  assign a_un = a_x < vl_n;
  assign b_ov = b_x > vl_p;
  assign b_un = b_x < vl_n;
  assign c_ov = c_x > tl_p;
  assign c_un = c_x < tl_n;

  // magnitudes
  assign a_abs = a_x[16] ? 17'(-a_x) : 17'(a_x);
  assign b_abs = b_x[16] ? 17'(-b_x) : 17'(b_x);
  assign c_abs = c_x[16] ? 17'(-c_x) : 17'(c_x);

  // direction wrap operand: d - 1 when positive, -d otherwise
  assign d_pos = !second_value[15] && (second_value != 16'sd0);
  assign d_neg = 17'(-b_x);
  assign dx    = d_pos ? 16'(second_value - 16'sd1) : d_neg[15:0];
  assign prod  = 32'(dx) * 32'(RECIP_360);

  // status by command, checks in priority order
  always_comb begin
    chk        = '0;
    chk.a_neg  = a_x[16];
    chk.a_mag  = a_abs[12:0];
    chk.c_neg  = c_x[16];
    chk.c_mag  = c_abs[12:0];
    chk.d_pos  = d_pos;
    chk.dx     = dx;
    chk.dq     = prod[RECIP_SHIFT +: 7];
    chk.status = ST_OK;
    unique case (command)
      CMD_RECT: begin
        chk.b_neg = b_x[16];
        chk.b_mag = b_abs[12:0];
        chk.mode  = rect_mode;
        priority if (a_ov) chk.status = ST_FIRST_OVER;
        else if (a_un)     chk.status = ST_FIRST_UNDER;
        else if (b_ov)     chk.status = ST_SECOND_OVER;
        else if (b_un)     chk.status = ST_SECOND_UNDER;
        else if (c_ov)     chk.status = ST_THIRD_OVER;
        else if (c_un)     chk.status = ST_THIRD_UNDER;
        else               chk.status = ST_OK;
      end
      CMD_POLAR: begin
        chk.polar = 1'b1;
        chk.mode  = polar_mode;
        priority if (a_ov) chk.status = ST_FIRST_OVER;
        else if (a_un)     chk.status = ST_FIRST_UNDER;
        else if (c_ov)     chk.status = ST_SECOND_OVER;
        else if (c_un)     chk.status = ST_SECOND_UNDER;
        else               chk.status = ST_OK;
      end
      default: begin
        // stop and the unused code: three zeros
        chk.a_neg = 1'b0;
        chk.a_mag = '0;
        chk.c_neg = 1'b0;
        chk.c_mag = '0;
        chk.mode  = stop_mode;
      end
    endcase
    chk.err = (chk.status != ST_OK);
  end

endmodule

`default_nettype wire

[rtl/mcfe_pack.sv]
// ---------------------------------------------------------------------------
// mcfe_pack
// direction remainder correction, value packing and check byte
// ---------------------------------------------------------------------------
`default_nettype none

module mcfe_pack import mcfe_pkg::*; (
  input  wire chk_t chk,
  output frm_t      frm
);

  logic [15:0] qx360;
  logic [16:0] r0;
  logic [8:0]  r1;
  logic [12:0] dir;
  logic        b_neg;
  logic [12:0] b_mag;
  logic [7:0]  chk_byte;

  // remainder of dx by 360, quotient estimate corrected once
  assign qx360 = 16'({chk.dq, 8'b0}) + 16'({chk.dq, 6'b0})
               + 16'({chk.dq, 5'b0}) + 16'({chk.dq, 3'b0});
  assign r0    = 17'(chk.dx) - 17'(qx360);
  assign r1    = (r0 >= 17'(DEG_FULL)) ? 9'(r0 - 17'(DEG_FULL)) : r0[8:0];

  // positive directions land in 1..360, the rest in 0..359
  always_comb begin
    if (chk.d_pos) begin
      dir = 13'(r1) + 13'd1;
    end else if (r1 == 9'd0) begin
      dir = '0;
    end else begin
      dir = 13'(DEG_FULL - r1);
    end
  end

  assign b_neg = chk.polar ? 1'b0 : chk.b_neg;
  assign b_mag = chk.polar ? dir : chk.b_mag;

  // sign flag plus 6 + 7 bit magnitude split
  always_comb begin
    frm.err      = chk.err;
    frm.status   = chk.status;
    frm.bytes[0] = (chk.a_neg ? SIGN_FLAG : 8'h00) | {2'b00, chk.a_mag[12:7] & HI_MASK};
    frm.bytes[1] = {1'b0, chk.a_mag[6:0] & LO_MASK};
    frm.bytes[2] = (b_neg ? SIGN_FLAG : 8'h00) | {2'b00, b_mag[12:7] & HI_MASK};
    frm.bytes[3] = {1'b0, b_mag[6:0] & LO_MASK};
    frm.bytes[4] = (chk.c_neg ? SIGN_FLAG : 8'h00) | {2'b00, chk.c_mag[12:7] & HI_MASK};
    frm.bytes[5] = {1'b0, chk.c_mag[6:0] & LO_MASK};
    // xor check over the six value bytes
    chk_byte     = frm.bytes[0] ^ frm.bytes[1] ^ frm.bytes[2]
                 ^ frm.bytes[3] ^ frm.bytes[4] ^ frm.bytes[5];
    frm.bytes[6] = chk_byte;
    frm.bytes[7] = chk.mode;
  end

endmodule

`default_nettype wire

[rtl/mcfe_serial.sv]
// ---------------------------------------------------------------------------
// mcfe_serial
// result register: shifts a frame out one byte per transfer
// ---------------------------------------------------------------------------
`default_nettype none

module mcfe_serial import mcfe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load_valid,
  input  wire frm_t       load_frm,
  output logic            ready,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_frame_byte,
  output logic            out_last,
  output logic [2:0]      out_status
);

`include "motion_command_frame_encoder_core_macros.svh"

  logic         v_r, v_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic         err_r;
  logic [2:0]   status_r;
  frame_bytes_t bytes_r;
  logic         xfer;

  assign out_valid      = v_r;
  assign out_frame_byte = bytes_r[0];
  assign out_last       = err_r || (idx_r == FRAME_LAST);
  assign out_status     = status_r;
  assign xfer           = v_r && !out_stall;
  assign ready          = !v_r || (xfer && out_last);

  // control next state
  always_comb begin
    v_nxt   = v_r;
    idx_nxt = idx_r;
    if (ready) begin
      v_nxt   = load_valid;
      idx_nxt = '0;
    end else if (xfer) begin
      idx_nxt = 3'(idx_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      idx_r <= '0;
    end else begin
      v_r   <= v_nxt;
      idx_r <= idx_nxt;
    end
  end

  // payload: load a new frame or shift on transfer
  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      err_r    <= load_frm.err;
      status_r <= load_frm.status;
      bytes_r  <= load_frm.err ? '0 : load_frm.bytes;
    end else if (xfer) begin
      bytes_r  <= {8'h00, bytes_r[7:1]};
    end
  end

  `MCFE_ASSERT(a_last_rewinds, (xfer && out_last) |=> (idx_r == 3'd0), "index not rewound")
  `MCFE_ASSERT(a_mid_advances, (xfer && !out_last) |=> (out_valid && (idx_r == 3'($past(idx_r) + 3'd1))), "frame byte lost")
  `MCFE_ASSERT_NEVER(a_err_shape, out_valid && (out_status != ST_OK) && ((out_frame_byte != 8'h00) || !out_last), "bad error result")

endmodule

`default_nettype wire

[rtl/motion_command_frame_encoder_core.sv]
// ---------------------------------------------------------------------------
// motion_command_frame_encoder_core
// motion command range check and eight-byte frame encoder
// ---------------------------------------------------------------------------
// a command passes the input, checked command and result registers before its
// first result byte is offered; a frame leaves as eight byte transfers and an
//   error result as one, the result register shifting one byte per transfer
// input and check stages accept a new command every cycle while free
// reset: rst_n synchronous, active low; clears pipeline valids and loads
//   the configuration registers with their reset values
`default_nettype none

module motion_command_frame_encoder_core import mcfe_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic signed [15:0] in_first_value,
  input  wire logic signed [15:0] in_second_value,
  input  wire logic signed [15:0] in_turn_rate,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_frame_byte,
  output logic                    out_last,
  output logic [2:0]              out_status,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [12:0]        cfg_data
);

  logic [12:0]        vel_limit_r, turn_limit_r;
  logic [7:0]         rect_mode_r, polar_mode_r, stop_mode_r;
  logic               in_v_r, in_v_nxt;
  logic [1:0]         cmd_r;
  logic signed [15:0] a_r, b_r, c_r;
  logic               chk_v_r, chk_v_nxt;
  chk_t               chk_c, chk_r;
  frm_t               frm_c;
  logic               ser_ready;
  logic               s2_ready;
  logic               in_xfer;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_limit_r  <= VEL_LIMIT_RST;
      turn_limit_r <= TURN_LIMIT_RST;
      rect_mode_r  <= RECT_MODE_RST;
      polar_mode_r <= POLAR_MODE_RST;
      stop_mode_r  <= STOP_MODE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_VEL_LIMIT:  vel_limit_r  <= cfg_data;
        CFG_TURN_LIMIT: turn_limit_r <= cfg_data;
        CFG_RECT_MODE:  rect_mode_r  <= cfg_data[7:0];
        CFG_POLAR_MODE: polar_mode_r <= cfg_data[7:0];
        CFG_STOP_MODE:  stop_mode_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign s2_ready = !chk_v_r || ser_ready;
  assign in_stall = in_v_r && !s2_ready;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_xfer) begin
      in_v_nxt = 1'b1;
    end else if (s2_ready) begin
      in_v_nxt = 1'b0;
    end
    chk_v_nxt = s2_ready ? in_v_r : chk_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      chk_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= in_command;
      a_r   <= in_first_value;
      b_r   <= in_second_value;
      c_r   <= in_turn_rate;
    end
  end

  mcfe_check u_check (
    .command      (cmd_r),
    .first_value  (a_r),
    .second_value (b_r),
    .turn_rate    (c_r),
    .vel_limit    (vel_limit_r),
    .turn_limit   (turn_limit_r),
    .rect_mode    (rect_mode_r),
    .polar_mode   (polar_mode_r),
    .stop_mode    (stop_mode_r),
    .chk          (chk_c)
  );

  // checked command register
  always_ff @(posedge clk) begin
    if (s2_ready && in_v_r) begin
      chk_r <= chk_c;
    end
  end

  mcfe_pack u_pack (
    .chk (chk_r),
    .frm (frm_c)
  );

  mcfe_serial u_serial (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_valid     (chk_v_r),
    .load_frm       (frm_c),
    .ready          (ser_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire

[bench/mcfe_frame_checker.sv]
// ---------------------------------------------------------------------------
// mcfe_frame_checker
// watches the command, result and register ports of the frame encoder,
// predicts every frame byte or error result and compares each transfer
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module mcfe_frame_checker import mcfe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_first_value,
  input  logic signed [15:0] in_second_value,
  input  logic signed [15:0] in_turn_rate,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_frame_byte,
  input  logic               out_last,
  input  logic [2:0]         out_status,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  output int                 bytes_outstanding,
  output int                 mismatch_count
);

  localparam int HEADING_SPAN = 360;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic [2:0] status;
  } frame_result_t;

  frame_result_t bytes_due[$];

  // shadow copy of the register file
  logic [12:0] vel_limit;
  logic [12:0] turn_limit;
  logic [7:0]  rect_mode;
  logic [7:0]  polar_mode;
  logic [7:0]  stop_mode;
  int          errors = 0;

  initial begin
    bytes_outstanding = 0;
    mismatch_count    = 0;
  end

  function automatic void push_error(logic [2:0] code);
    frame_result_t r;
    r.frame_byte = 8'h00;
    r.last       = 1'b1;
    r.status     = code;
    bytes_due.push_back(r);
  endfunction

  // sign flag plus 13-bit magnitude, split 6 + 7 over two bytes
  function automatic logic [15:0] pack_value(int v);
    logic [7:0] hi;
    logic [7:0] lo;
    int         mag;
    mag = (v < 0) ? -v : v;
    hi  = ((v < 0) ? SIGN_FLAG : 8'h00) | {2'b00, 6'(mag >> 7) & HI_MASK};
    lo  = {1'b0, 7'(mag) & LO_MASK};
    return {hi, lo};
  endfunction

  // direction into 1..360 when positive, 0..359 when negative
  function automatic int wrap_heading(int d);
    int r;
    if (d > 0) return ((d - 1) % HEADING_SPAN) + 1;
    if (d < 0) begin
      r = (-d) % HEADING_SPAN;
      return (r == 0) ? 0 : HEADING_SPAN - r;
    end
    return 0;
  endfunction

  function automatic void push_frame(int a, int b, int c, logic [7:0] mode);
    logic [7:0]    f [FRAME_BYTES];
    logic [15:0]   p;
    frame_result_t r;
    p = pack_value(a);
    f[0] = p[15:8];
    f[1] = p[7:0];
    p = pack_value(b);
    f[2] = p[15:8];
    f[3] = p[7:0];
    p = pack_value(c);
    f[4] = p[15:8];
    f[5] = p[7:0];
    f[6] = f[0] ^ f[1] ^ f[2] ^ f[3] ^ f[4] ^ f[5];
    f[7] = mode;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      r.frame_byte = f[k];
      r.last       = (k == FRAME_BYTES - 1);
      r.status     = ST_OK;
      bytes_due.push_back(r);
    end
  endfunction

  // range checks in priority order, then the frame
  function automatic void encode_command(logic [1:0] cmd, int a, int b, int c);
    int vl;
    int tl;
    vl = int'(vel_limit);
    tl = int'(turn_limit);
    case (cmd)
      CMD_RECT: begin
        if (a > vl)       push_error(ST_FIRST_OVER);
        else if (a < -vl) push_error(ST_FIRST_UNDER);
        else if (b > vl)  push_error(ST_SECOND_OVER);
        else if (b < -vl) push_error(ST_SECOND_UNDER);
        else if (c > tl)  push_error(ST_THIRD_OVER);
        else if (c < -tl) push_error(ST_THIRD_UNDER);
        else              push_frame(a, b, c, rect_mode);
      end
      CMD_POLAR: begin
        // direction is never range checked; turn rate takes the second slot
        if (a > vl)       push_error(ST_FIRST_OVER);
        else if (a < -vl) push_error(ST_FIRST_UNDER);
        else if (c > tl)  push_error(ST_SECOND_OVER);
        else if (c < -tl) push_error(ST_SECOND_UNDER);
        else              push_frame(a, wrap_heading(b), c, polar_mode);
      end
      // stop, and the unused code, send three zeros
      default: push_frame(0, 0, 0, stop_mode);
    endcase
  endfunction

  always @(posedge clk) begin
    frame_result_t seen;
    frame_result_t want;
    if (!rst_n) begin
      vel_limit  = VEL_LIMIT_RST;
      turn_limit = TURN_LIMIT_RST;
      rect_mode  = RECT_MODE_RST;
      polar_mode = POLAR_MODE_RST;
      stop_mode  = STOP_MODE_RST;
      bytes_due.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_VEL_LIMIT:  vel_limit  = cfg_data;
          CFG_TURN_LIMIT: turn_limit = cfg_data;
          CFG_RECT_MODE:  rect_mode  = cfg_data[7:0];
          CFG_POLAR_MODE: polar_mode = cfg_data[7:0];
          CFG_STOP_MODE:  stop_mode  = cfg_data[7:0];
          default: ;
        endcase
      end

      // result transfer against the oldest expectation
      if (out_valid && !out_stall) begin
        seen = '{out_frame_byte, out_last, out_status};
        if (bytes_due.size() == 0) begin
          $display("%0t: result with nothing expected: byte %h last %b status %0d",
                   $time, seen.frame_byte, seen.last, seen.status);
          errors++;
        end else begin
          want = bytes_due.pop_front();
          if (seen.frame_byte !== want.frame_byte) begin
            $display("%0t: frame_byte mismatch: expected %h actual %h",
                     $time, want.frame_byte, seen.frame_byte);
            errors++;
          end
          if (seen.last !== want.last) begin
            $display("%0t: last mismatch: expected %b actual %b",
                     $time, want.last, seen.last);
            errors++;
          end
          if (seen.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, seen.status);
            errors++;
          end
        end
      end

      // command transfer
      if (in_valid && !in_stall)
        encode_command(in_command, int'(in_first_value), int'(in_second_value),
                       int'(in_turn_rate));
    end
    bytes_outstanding <= bytes_due.size();
    mismatch_count    <= errors;
  end

endmodule

[bench/motion_command_frame_encoder_core_tb.sv]
// ---------------------------------------------------------------------------
// motion_command_frame_encoder_core_tb
// drives directed and random motion commands through the frame encoder
// under several register settings and idle patterns; the checker beside
// the block predicts and compares every result transfer
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module motion_command_frame_encoder_core_tb import mcfe_pkg::*; ();

  localparam logic [1:0] CMD_SPARE        = 2'd3;
  localparam int         CYCLE_LIMIT      = 400000;
  localparam int         DRAIN_CYCLES     = 40;
  localparam int         RANDOM_PER_PHASE = 27;
  localparam int         PHASES           = 4;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command      = CMD_STOP;
  logic signed [15:0] in_first_value  = '0;
  logic signed [15:0] in_second_value = '0;
  logic signed [15:0] in_turn_rate    = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic [7:0]         out_frame_byte;
  logic               out_last;
  logic [2:0]         out_status;
  logic               cfg_wr_en       = 1'b0;
  logic [2:0]         cfg_index       = CFG_VEL_LIMIT;
  logic [12:0]        cfg_data        = '0;
  int                 bytes_outstanding;
  int                 mismatch_count;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;

  motion_command_frame_encoder_core DUT (.*);

  mcfe_frame_checker checker_inst (.*);

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one command transfer, with random idle cycles ahead of it
  task automatic send_command(logic [1:0] cmd, logic signed [15:0] a, b, c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_first_value  <= a;
    in_second_value <= b;
    in_turn_rate    <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // lower valid and wait for every expected result
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_outstanding != 0) @(posedge clk);
  endtask

  task automatic load_register(logic [2:0] idx, logic [12:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic write_settings(logic [12:0] vel, turn, logic [7:0] rect, polar, stop);
    load_register(CFG_VEL_LIMIT, vel);
    load_register(CFG_TURN_LIMIT, turn);
    load_register(CFG_RECT_MODE, 13'(rect));
    load_register(CFG_POLAR_MODE, 13'(polar));
    load_register(CFG_STOP_MODE, 13'(stop));
    cfg_wr_en <= 1'b0;
  endtask

  // mostly in range, some on and just past the limit, some anywhere
  function automatic logic signed [15:0] pick_value(int lim);
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) return 16'(int'($urandom_range(2 * lim)) - lim);
    if (sel < 75) return $urandom_range(1) ? 16'(lim) : 16'(-lim);
    if (sel < 85) return $urandom_range(1) ? 16'(lim + 1) : 16'(-lim - 1);
    return 16'($urandom);
  endfunction

  // polar direction: anywhere, exact multiples of a full turn, or near zero
  function automatic logic signed [15:0] pick_heading();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return 16'($urandom);
    if (sel < 75) return 16'((int'($urandom_range(182)) - 91) * 360);
    return 16'(int'($urandom_range(1440)) - 720);
  endfunction

  task automatic send_random(int vl, int tl);
    int sel;
    sel = $urandom_range(99);
    if (sel < 40)
      send_command(CMD_RECT, pick_value(vl), pick_value(vl), pick_value(tl));
    else if (sel < 80)
      send_command(CMD_POLAR, pick_value(vl), pick_heading(), pick_value(tl));
    else if (sel < 94)
      send_command(CMD_STOP, 16'($urandom), 16'($urandom), 16'($urandom));
    else
      send_command(CMD_SPARE, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int          vl;
    int          tl;
    logic [7:0]  rm;
    logic [7:0]  pm;
    logic [7:0]  sm;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed commands under the reset settings
    send_command(CMD_RECT, 0, 0, 0);
    send_command(CMD_RECT, 4000, -4000, 360);
    send_command(CMD_RECT, -4000, 4000, -360);
    send_command(CMD_RECT, 4001, 0, 0);
    send_command(CMD_RECT, -4001, 0, 0);
    send_command(CMD_RECT, 0, 4001, 0);
    send_command(CMD_RECT, 0, -4001, 0);
    send_command(CMD_RECT, 0, 0, 361);
    send_command(CMD_RECT, 0, 0, -361);
    // first failing check wins
    send_command(CMD_RECT, 32767, -32768, 32767);
    send_command(CMD_RECT, -32768, 32767, -32768);
    // direction wrap at whole turns and at the extremes, then polar range errors
    send_command(CMD_POLAR, 100, 360, 10);
    send_command(CMD_POLAR, -100, 720, -10);
    send_command(CMD_POLAR, 100, -360, 0);
    send_command(CMD_POLAR, 4000, 0, 360);
    send_command(CMD_POLAR, -4000, -1, -360);
    send_command(CMD_POLAR, 1, 32767, 1);
    send_command(CMD_POLAR, 2, -32768, 2);
    send_command(CMD_POLAR, 4001, 0, 0);
    send_command(CMD_POLAR, -4001, 0, 0);
    send_command(CMD_POLAR, 0, 32767, 361);
    send_command(CMD_POLAR, 0, 0, -361);
    // stop ignores its operands, the unused code acts as stop
    send_command(CMD_STOP, -32768, 32767, -1);
    send_command(CMD_SPARE, 32767, -32768, 12345);
    drain();

    // random phases, each with its own settings and idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          vl = 8191; tl = 8191; rm = 8'hFF; pm = 8'h00; sm = 8'hA5;
          send_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          vl = 0; tl = 0; rm = 8'h00; pm = 8'hFF; sm = 8'h5A;
          send_idle_pct = 79;
          stall_pct <= 0;
        end
        2: begin
          vl = $urandom_range(8191); tl = $urandom_range(8191);
          rm = 8'($urandom); pm = 8'($urandom); sm = 8'($urandom);
          send_idle_pct = 0;
          stall_pct <= 79;
        end
        default: begin
          vl = int'(VEL_LIMIT_RST); tl = int'(TURN_LIMIT_RST);
          rm = RECT_MODE_RST; pm = POLAR_MODE_RST; sm = STOP_MODE_RST;
          send_idle_pct = 21;
          stall_pct <= 21;
        end
      endcase
      write_settings(13'(vl), 13'(tl), rm, pm, sm);
      repeat (RANDOM_PER_PHASE) send_random(vl, tl);
      drain();
    end

    stall_pct <= 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
